// ===== rtl/rgbx256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbx256_pkg
// Shared types, constants and helper functions for the RGB to xterm-256
// nearest-color search.
// ----------------------------------------------------------------------------
package rgbx256_pkg;

  localparam int unsigned ChanW       = 8;
  localparam int unsigned LvlW        = 3;
  localparam int unsigned ChanDistW   = 7;
  localparam int unsigned CubeDistW   = 8;
  localparam int unsigned DistW       = 10;
  localparam int unsigned GrayKW      = 5;
  localparam int unsigned IndexW      = 8;
  localparam int unsigned PixelW      = 24;

  localparam int unsigned NumGray     = 24;
  localparam int unsigned NumLevels   = 6;
  localparam int unsigned CubeSide    = 6;
  localparam int unsigned CubeEntries = 216;
  localparam int unsigned IndexOffset = 16;
  localparam int unsigned GrayBase    = 8;
  localparam int unsigned GrayStep    = 10;
  localparam int unsigned CubeStep    = 40;
  localparam int unsigned CubeOffset  = 55;

  // Decision points between adjacent cube levels; a value on the point
  // itself takes the higher level.
  localparam logic [ChanW-1:0] CubeThr [NumLevels-1] = '{
    8'd48, 8'd115, 8'd155, 8'd195, 8'd235
  };

  typedef struct packed {
    logic [LvlW-1:0]      lvl;
    logic [ChanDistW-1:0] gap;
  } chan_near_t;

  typedef struct packed {
    logic [DistW-1:0]  gap;
    logic [GrayKW-1:0] k;
  } gray_cand_t;

  function automatic logic [ChanW-1:0] cube_level(logic [LvlW-1:0] x);
    return (x == '0) ? '0 : ChanW'(CubeStep * int'(x) + CubeOffset);
  endfunction

  function automatic logic [ChanW-1:0] gray_level(logic [GrayKW-1:0] k);
    return ChanW'(GrayBase + GrayStep * int'(k));
  endfunction

  function automatic logic [ChanW-1:0] abs_diff(logic [ChanW-1:0] a,
                                                logic [ChanW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Keep the higher-indexed candidate on equal distance.
  function automatic gray_cand_t gray_pick(gray_cand_t lo, gray_cand_t hi);
    return (hi.gap <= lo.gap) ? hi : lo;
  endfunction

endpackage

// ===== rtl/rgbx256_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbx256_if
// Valid/ready stream interfaces for pixels in and palette indexes out.
// ----------------------------------------------------------------------------
interface rgbx256_pix_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_rgb;

  modport source (output valid, output pixel_rgb, input ready);
  modport sink   (input valid, input pixel_rgb, output ready);
endinterface

interface rgbx256_idx_if;
  logic       valid;
  logic       ready;
  logic [7:0] color_index;

  modport source (output valid, output color_index, input ready);
  modport sink   (input valid, input color_index, output ready);
endinterface

// ===== rtl/rgbx256_chan_near.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbx256_chan_near
// Nearest color-cube level for one 8-bit channel and its distance.
// ----------------------------------------------------------------------------
module rgbx256_chan_near
  import rgbx256_pkg::*;
(
  input  logic [ChanW-1:0] chan_i,
  output chan_near_t       near_o
);

  logic [LvlW-1:0]  lvl;
  logic [ChanW-1:0] diff;

  always_comb begin
    lvl = '0;
    for (int i = 0; i < NumLevels - 1; i++) begin
      lvl = lvl + LvlW'(chan_i >= CubeThr[i]);
    end
    diff = abs_diff(chan_i, cube_level(lvl));
  end

  // Nearest-level distance never exceeds 47, so drop the top bit.
  assign near_o.lvl = lvl;
  assign near_o.gap = diff[ChanDistW-1:0];

endmodule

// ===== rtl/rgb_to_xterm256_nearest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_xterm256_nearest
// Maps a 24-bit RGB pixel to the nearest xterm-256 palette index (16..255)
// by L1 distance over the 216-entry color cube and the 24-step gray ramp.
// ----------------------------------------------------------------------------
//
//  port     | dir | payload             | meaning
//  ---------+-----+---------------------+------------------------------------
//  pix_i    | in  | pixel_rgb   [23:0]  | red 23:16, green 15:8, blue 7:0
//  idx_o    | out | color_index [7:0]   | nearest palette index
//
//  One pixel per clock sustained while idx_o is ready; each transaction
//  passes through the five-stage search pipeline from pix_i to idx_o.
//  Reset clears the stage valid bits only; data registers are not reset.
//  Each stage holds while the stage after it is full and stalled, and moves
//  into an empty slot otherwise, so bubbles close up and a stall on idx_o
//  backs up without losing or repeating a transaction.
//
//  Stages:
//    1  capture the pixel
//    2  per-channel nearest cube level; distances to all 24 grays
//    3  cube distance and entry; reduce grays 24 -> 6
//    4  reduce grays 6 -> 1
//    5  cube vs. gray, form the palette index (output register)
//
//  The cube term is separable: each channel independently picks its nearest
//  level (higher level on a tie), which also yields the highest cube entry
//  among equal-distance ones. Grays sit above the cube in the palette, so a
//  gray wins on equal distance.
// ----------------------------------------------------------------------------
module rgb_to_xterm256_nearest
  import rgbx256_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rgbx256_pix_if.sink          pix_i,
  rgbx256_idx_if.source        idx_o
);

  localparam int unsigned NumStages = 5;
  localparam int unsigned NumGroups = 6;
  localparam int unsigned GroupSize = NumGray / NumGroups;

  // Valid bits and per-stage room; a stage may load when empty or when
  // the next stage takes its contents this cycle.
  logic [NumStages:1] vld_q;
  logic [NumStages:1] rdy;

  always_comb begin
    rdy[NumStages] = !vld_q[NumStages] || idx_o.ready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign pix_i.ready = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) begin
        vld_q[1] <= pix_i.valid;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the pixel
  // --------------------------------------------------------------------------
  logic [ChanW-1:0] red_q, grn_q, blu_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && pix_i.valid) begin
      red_q <= pix_i.pixel_rgb[23:16];
      grn_q <= pix_i.pixel_rgb[15:8];
      blu_q <= pix_i.pixel_rgb[7:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: nearest cube level per channel, all gray distances
  // --------------------------------------------------------------------------
  chan_near_t red_near, grn_near, blu_near;
  chan_near_t red_near_q, grn_near_q, blu_near_q;
  logic [DistW-1:0] gray_dist_d [NumGray];
  logic [DistW-1:0] gray_dist_q [NumGray];

  rgbx256_chan_near u_red_near (.chan_i(red_q), .near_o(red_near));
  rgbx256_chan_near u_grn_near (.chan_i(grn_q), .near_o(grn_near));
  rgbx256_chan_near u_blu_near (.chan_i(blu_q), .near_o(blu_near));

  always_comb begin
    for (int k = 0; k < NumGray; k++) begin
      gray_dist_d[k] = DistW'(abs_diff(red_q, gray_level(GrayKW'(k))))
                     + DistW'(abs_diff(grn_q, gray_level(GrayKW'(k))))
                     + DistW'(abs_diff(blu_q, gray_level(GrayKW'(k))));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && vld_q[1]) begin
      red_near_q  <= red_near;
      grn_near_q  <= grn_near;
      blu_near_q  <= blu_near;
      gray_dist_q <= gray_dist_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: cube distance and entry; first gray reduction (groups of four)
  // --------------------------------------------------------------------------
  logic [CubeDistW-1:0] cube_dist_d, cube_dist_q, cube_dist_p_q;
  logic [IndexW-1:0]    cube_entry_d, cube_entry_q, cube_entry_p_q;
  gray_cand_t           grp_best_d [NumGroups];
  gray_cand_t           grp_best_q [NumGroups];

  always_comb begin
    gray_cand_t c0, c1, c2, c3;
    cube_dist_d  = CubeDistW'(red_near_q.gap) + CubeDistW'(grn_near_q.gap)
                 + CubeDistW'(blu_near_q.gap);
    cube_entry_d = IndexW'(int'(red_near_q.lvl) * CubeSide * CubeSide
                 + int'(grn_near_q.lvl) * CubeSide + int'(blu_near_q.lvl));
    for (int g = 0; g < NumGroups; g++) begin
      c0 = '{gap: gray_dist_q[g*GroupSize],     k: GrayKW'(g*GroupSize)};
      c1 = '{gap: gray_dist_q[g*GroupSize + 1], k: GrayKW'(g*GroupSize + 1)};
      c2 = '{gap: gray_dist_q[g*GroupSize + 2], k: GrayKW'(g*GroupSize + 2)};
      c3 = '{gap: gray_dist_q[g*GroupSize + 3], k: GrayKW'(g*GroupSize + 3)};
      grp_best_d[g] = gray_pick(gray_pick(c0, c1), gray_pick(c2, c3));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3] && vld_q[2]) begin
      cube_dist_q  <= cube_dist_d;
      cube_entry_q <= cube_entry_d;
      grp_best_q   <= grp_best_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: final gray reduction, groups in ascending order
  // --------------------------------------------------------------------------
  gray_cand_t gray_best_d, gray_best_q;

  always_comb begin
    gray_best_d = gray_pick(gray_pick(gray_pick(grp_best_q[0], grp_best_q[1]),
                                      gray_pick(grp_best_q[2], grp_best_q[3])),
                            gray_pick(grp_best_q[4], grp_best_q[5]));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4] && vld_q[3]) begin
      gray_best_q    <= gray_best_d;
      cube_dist_p_q  <= cube_dist_q;
      cube_entry_p_q <= cube_entry_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: cube vs. gray; gray sits higher in the palette and wins ties
  // --------------------------------------------------------------------------
  logic [IndexW-1:0] index_d, index_q;

  always_comb begin
    if (gray_best_q.gap <= DistW'(cube_dist_p_q)) begin
      index_d = IndexW'(CubeEntries + IndexOffset + int'(gray_best_q.k));
    end else begin
      index_d = IndexW'(int'(cube_entry_p_q) + IndexOffset);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5] && vld_q[4]) begin
      index_q <= index_d;
    end
  end

  assign idx_o.valid       = vld_q[NumStages];
  assign idx_o.color_index = index_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream test of rgb_to_xterm256_nearest: pixels go in, palette indexes come
// out. A brute-force search over all 240 palette entries predicts each index,
// and every result is compared in order against it. Traffic runs in phases
// with different amounts of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------

// Holds the predicted palette index for every pixel taken by the block, in
// the order the pixels were taken.
class xterm_index_board;
  typedef struct packed {
    logic [23:0] pixel;
    logic [7:0]  color_index;
  } index_expect_t;

  index_expect_t expected_indexes[$];
  int unsigned   mismatches;

  // Score all 240 entries by L1 distance, walking down from the top so that
  // a strictly smaller distance is needed to replace the best: on a tie the
  // higher entry stays.
  function automatic logic [7:0] nearest_xterm_index(logic [23:0] px);
    int unsigned chan [3];
    int unsigned lvl [3];
    int unsigned digit;
    int unsigned divisor;
    int unsigned l1_dist;
    int unsigned best_dist;
    int unsigned best_entry;
    chan[0] = px[23:16];
    chan[1] = px[15:8];
    chan[2] = px[7:0];
    best_dist = 32'hFFFF_FFFF;
    best_entry = 0;
    for (int e = rgbx256_pkg::CubeEntries + rgbx256_pkg::NumGray - 1; e >= 0; e--) begin
      divisor = 36;
      for (int c = 0; c < 3; c++) begin
        if (e >= rgbx256_pkg::CubeEntries) begin
          lvl[c] = rgbx256_pkg::GrayBase
                 + (e - rgbx256_pkg::CubeEntries) * rgbx256_pkg::GrayStep;
        end else begin
          digit = (e / divisor) % 6;
          lvl[c] = (digit == 0) ? 0
                 : digit * rgbx256_pkg::CubeStep + rgbx256_pkg::CubeOffset;
        end
        divisor = divisor / 6;
      end
      l1_dist = 0;
      for (int c = 0; c < 3; c++) begin
        l1_dist += (chan[c] > lvl[c]) ? chan[c] - lvl[c] : lvl[c] - chan[c];
      end
      if (l1_dist < best_dist) begin
        best_dist = l1_dist;
        best_entry = e;
      end
    end
    return 8'(best_entry + rgbx256_pkg::IndexOffset);
  endfunction

  function void note_pixel(logic [23:0] px);
    index_expect_t item;
    item.pixel = px;
    item.color_index = nearest_xterm_index(px);
    expected_indexes.push_back(item);
  endfunction

  function void check_index(logic [7:0] got);
    index_expect_t item;
    if (expected_indexes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: index %0d arrived with no pixel outstanding", got);
      end
      return;
    end
    item = expected_indexes.pop_front();
    if (got !== item.color_index) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: pixel %06h: color_index expected %0d, got %0d",
                 item.pixel, item.color_index, got);
      end
    end
  endfunction
endclass

module tb_top;

  // Idle cycles in a row (nothing taken on either side) before giving up.
  // Even at 77% back-pressure this limit is far past anything a working
  // block produces.
  localparam int unsigned WatchdogLimit  = 4000;
  // Pipeline is five deep; leave a margin for a stray extra transaction.
  localparam int unsigned DrainCycles    = 20;
  localparam int unsigned NumPhases      = 4;
  localparam int unsigned RandomPerPhase = 463;

  // Sender idle and receiver stall, percent of cycles, per phase.
  localparam int unsigned SrcIdlePct   [NumPhases] = '{0, 77, 0, 19};
  localparam int unsigned SinkStallPct [NumPhases] = '{0, 0, 77, 19};

  localparam int CubeLevels [6] = '{0, 95, 135, 175, 215, 255};
  // Points where the nearest cube level changes.
  localparam int CubeSplits [5] = '{48, 115, 155, 195, 235};

  // Corners, pure primaries, near-black, ties between grays, ties between
  // gray and cube, and values right at and just below the cube decision
  // points.
  localparam logic [23:0] DirectedPixels [25] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'h010101, 24'h040404, 24'h080808, 24'h0D0D0D, 24'hEEEEEE,
    24'hF3F3F3, 24'h2F2F2F, 24'h303030, 24'h737373, 24'h9B9B9B,
    24'hC3C3C3, 24'hEBEBEB, 24'h5F87AF, 24'h30739B, 24'h2F729A,
    24'hC3EB30, 24'hAAAAAA, 24'h123456, 24'h5A5A5A, 24'hFF00FF
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  rgbx256_pix_if pix_if ();
  rgbx256_idx_if idx_if ();

  rgb_to_xterm256_nearest DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .idx_o  (idx_if)
  );

  xterm_index_board board = new();

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned idle_cycles    = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Pick a pixel: a quarter fully random, the rest clustered around palette
  // levels, along the gray axis, or on the decision points, where ties and
  // off-by-one choices live.
  function automatic logic [23:0] stress_pixel();
    int unsigned mode;
    int          anchor;
    int          ch [3];
    mode = $urandom_range(3);
    if (mode == 0) begin
      return 24'($urandom);
    end
    anchor = 8 + 10 * int'($urandom_range(23));
    for (int c = 0; c < 3; c++) begin
      case (mode)
        1: begin
          if ($urandom_range(1) == 1) begin
            ch[c] = CubeLevels[$urandom_range(5)];
          end else begin
            ch[c] = 8 + 10 * int'($urandom_range(23));
          end
          ch[c] += int'($urandom_range(8)) - 4;
        end
        2: begin
          ch[c] = anchor + int'($urandom_range(12)) - 6;
        end
        default: begin
          if ($urandom_range(1) == 1) begin
            ch[c] = CubeSplits[$urandom_range(4)];
          end else begin
            ch[c] = 13 + 10 * int'($urandom_range(22));
          end
          ch[c] += int'($urandom_range(2)) - 1;
        end
      endcase
      if (ch[c] < 0) ch[c] = 0;
      if (ch[c] > 255) ch[c] = 255;
    end
    return {8'(ch[0]), 8'(ch[1]), 8'(ch[2])};
  endfunction

  // Offer one pixel, idling first as the phase asks, and hold it until the
  // block takes it.
  task automatic send_pixel(input logic [23:0] px);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid     <= 1'b1;
    pix_if.pixel_rgb <= px;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
    board.note_pixel(px);
  endtask

  // Receiver: check each transaction on the output side using values from
  // just before the edge, then decide whether to stall the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && idx_if.valid && idx_if.ready) begin
      board.check_index(idx_if.color_index);
    end
    idx_if.ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
  end

  // Watchdog: reset the count on any transaction on either side.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (pix_if.valid && pix_if.ready) ||
        (idx_if.valid && idx_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    pix_if.valid     = 1'b0;
    pix_if.pixel_rgb = '0;
    idx_if.ready     = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      src_idle_pct   = SrcIdlePct[ph];
      sink_stall_pct = SinkStallPct[ph];
      if (ph == 0) begin
        foreach (DirectedPixels[i]) send_pixel(DirectedPixels[i]);
      end
      repeat (RandomPerPhase) send_pixel(stress_pixel());
      // Drop valid and let the pipeline empty before the next phase.
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
      while (board.expected_indexes.size() != 0) @(posedge clk_i);
    end

    // Catch anything extra the block might still push out.
    repeat (DrainCycles) @(posedge clk_i);

    if (board.mismatches == 0 && board.expected_indexes.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
